### hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property sampled on the rising edge, quiet during reset.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true.
`define CHK_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

### hw/rtl/cct_pkg.sv
`timescale 1ns / 1ps
package cct_pkg;

    localparam int TABLE_DEPTH_DEF = 65536;
    localparam int NW = 17;

    localparam logic [27:0] LINK_FREE  = 28'h0000000;
    localparam logic [27:0] LINK_FIRST = 28'h0000002;
    localparam logic [27:0] LINK_LAST  = 28'hFFFFFEF;
    localparam logic [27:0] LINK_END   = 28'hFFFFFF8;

    localparam logic [1:0] CFG_BPS = 2'd0;
    localparam logic [1:0] CFG_SPC = 2'd1;
    localparam logic [1:0] CFG_TE  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_LIMIT = 2'd2;

    typedef enum logic [3:0] {
        CMD_GET    = 4'd0,
        CMD_SET    = 4'd1,
        CMD_ALLOC  = 4'd2,
        CMD_FREE   = 4'd3,
        CMD_RESIZE = 4'd4,
        CMD_DETACH = 4'd5,
        CMD_FINDB  = 4'd6,
        CMD_LAST   = 4'd7,
        CMD_PREV   = 4'd8,
        CMD_COUNT  = 4'd9
    } cmd_t;

    typedef enum logic [15:0] {
        S_CLEAR   = 16'h0001,
        S_IDLE    = 16'h0002,
        S_DISP    = 16'h0004,
        S_RW_EV   = 16'h0008,
        S_DT_EV   = 16'h0010,
        S_SC_CHK  = 16'h0020,
        S_SC_EV   = 16'h0040,
        S_GR_CHK  = 16'h0080,
        S_GR_EV   = 16'h0100,
        S_GR_LINK = 16'h0200,
        S_TL_EV   = 16'h0400,
        S_WK_CHK  = 16'h0800,
        S_WK_EV   = 16'h1000,
        S_DT_FREE = 16'h2000,
        S_TL_END  = 16'h4000,
        S_DONE    = 16'h8000
    } state_t;

    typedef struct packed {
        logic [3:0]  command;
        logic [27:0] cluster;
        logic [27:0] other_cluster;
        logic [31:0] byte_count;
    } item_t;

    typedef struct packed {
        logic [27:0] result_cluster;
        logic [16:0] used_count;
        logic [1:0]  status;
    } result_t;

    typedef struct packed {
        state_t state;
        logic   accept;
        logic   grow;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic c_ge_n;
        logic c_bad;
        logic c_zero;
        logic c_eq_oc;
        logic nb_zero;
        logic idx_ge_n;
        logic rd_zero;
        logic rd_link;
        logic rd_ge_n;
        logic i_eq_k;
        logic steps_ge_n;
        logic wk_go;
        logic wk_err;
        logic clr_last;
    } sts_t;

endpackage

### hw/rtl/cct_ctrl.sv
`timescale 1ns / 1ps
module cct_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  cct_pkg::sts_t sts,
    output cct_pkg::ctl_t ctl,
    output logic          busy,
    output logic          done
);

    cct_pkg::state_t state_reg, state_next;
    logic            grow_reg, grow_next;
    logic            accept;

    assign accept = start && (state_reg == cct_pkg::S_IDLE);
    assign busy   = (state_reg != cct_pkg::S_IDLE);
    assign done   = (state_reg == cct_pkg::S_DONE);

    assign ctl.state  = state_reg;
    assign ctl.accept = accept;
    assign ctl.grow   = grow_reg;

    always_comb
    begin
        state_next = state_reg;
        grow_next  = grow_reg;
        case (state_reg)
            cct_pkg::S_CLEAR:
            begin
                if (sts.clr_last)
                    state_next = cct_pkg::S_IDLE;
            end
            cct_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = cct_pkg::S_DISP;
                    grow_next  = 1'b0;
                end
            end
            cct_pkg::S_DISP:
            begin
                case (sts.cmd)
                    cct_pkg::CMD_GET:
                        state_next = sts.c_ge_n ? cct_pkg::S_DONE : cct_pkg::S_RW_EV;
                    cct_pkg::CMD_ALLOC, cct_pkg::CMD_COUNT:
                        state_next = cct_pkg::S_SC_CHK;
                    cct_pkg::CMD_FREE, cct_pkg::CMD_LAST, cct_pkg::CMD_FINDB,
                    cct_pkg::CMD_PREV:
                        state_next = cct_pkg::S_WK_CHK;
                    cct_pkg::CMD_RESIZE:
                    begin
                        if (sts.nb_zero)
                            state_next = cct_pkg::S_WK_CHK;
                        else if (sts.c_zero)
                            state_next = cct_pkg::S_SC_CHK;
                        else if (sts.c_bad)
                            state_next = cct_pkg::S_DONE;
                        else
                            state_next = cct_pkg::S_GR_CHK;
                    end
                    cct_pkg::CMD_DETACH:
                        state_next = sts.c_ge_n ? cct_pkg::S_DONE : cct_pkg::S_DT_EV;
                    default:
                        state_next = cct_pkg::S_DONE;
                endcase
            end
            cct_pkg::S_RW_EV:
                state_next = cct_pkg::S_DONE;
            cct_pkg::S_DT_EV:
                state_next = sts.c_eq_oc ? cct_pkg::S_DONE : cct_pkg::S_WK_CHK;
            cct_pkg::S_SC_CHK:
                state_next = sts.idx_ge_n ? cct_pkg::S_DONE : cct_pkg::S_SC_EV;
            cct_pkg::S_SC_EV:
            begin
                if (sts.cmd == cct_pkg::CMD_COUNT || !sts.rd_zero)
                    state_next = cct_pkg::S_SC_CHK;
                else if (sts.cmd == cct_pkg::CMD_ALLOC)
                    state_next = cct_pkg::S_DONE;
                else
                    state_next = grow_reg ? cct_pkg::S_GR_LINK : cct_pkg::S_GR_CHK;
            end
            cct_pkg::S_GR_CHK:
            begin
                if (sts.i_eq_k)
                    state_next = cct_pkg::S_TL_EV;
                else if (sts.steps_ge_n)
                    state_next = cct_pkg::S_DONE;
                else
                    state_next = cct_pkg::S_GR_EV;
            end
            cct_pkg::S_GR_EV:
            begin
                if (!sts.rd_link)
                begin
                    state_next = cct_pkg::S_SC_CHK;
                    grow_next  = 1'b1;
                end
                else if (sts.rd_ge_n)
                    state_next = cct_pkg::S_DONE;
                else
                    state_next = cct_pkg::S_GR_CHK;
            end
            cct_pkg::S_GR_LINK:
                state_next = cct_pkg::S_GR_CHK;
            cct_pkg::S_TL_EV:
                state_next = sts.rd_link ? cct_pkg::S_WK_CHK : cct_pkg::S_DONE;
            cct_pkg::S_WK_CHK:
            begin
                if (sts.wk_go)
                    state_next = cct_pkg::S_WK_EV;
                else if (sts.cmd == cct_pkg::CMD_DETACH)
                    state_next = sts.wk_err ? cct_pkg::S_DONE : cct_pkg::S_DT_FREE;
                else if (sts.cmd == cct_pkg::CMD_RESIZE && !sts.nb_zero)
                    state_next = cct_pkg::S_TL_END;
                else
                    state_next = cct_pkg::S_DONE;
            end
            cct_pkg::S_WK_EV:
                state_next = cct_pkg::S_WK_CHK;
            cct_pkg::S_DT_FREE, cct_pkg::S_TL_END:
                state_next = cct_pkg::S_DONE;
            cct_pkg::S_DONE:
                state_next = cct_pkg::S_IDLE;
            default:
                state_next = cct_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cct_pkg::S_CLEAR;
            grow_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grow_reg  <= grow_next;
        end
    end

endmodule

### hw/rtl/cct_datapath.sv
`timescale 1ns / 1ps
module cct_datapath #(
    parameter int TABLE_DEPTH = cct_pkg::TABLE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  cct_pkg::ctl_t    ctl,
    input  cct_pkg::item_t   item,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_data,
    output cct_pkg::result_t result,
    output cct_pkg::sts_t    sts
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [27:0] mem [TABLE_DEPTH];

    logic [12:0] bps_reg;
    logic [7:0]  spc_reg;
    logic [16:0] te_reg;

    cct_pkg::cmd_t cmd_reg, cmd_next;
    logic [27:0] c_reg, c_next, oc_reg, oc_next, cur_reg, cur_next, prev_reg, prev_next;
    logic [27:0] head_reg, head_next, tgt_reg, tgt_next, nx_reg, nx_next, res_reg, res_next;
    logic [31:0] nb_reg, nb_next, k_reg, k_next;
    logic [16:0] idx_reg, idx_next, steps_reg, steps_next, cnt_reg, cnt_next;
    logic [1:0]  st_reg, st_next;
    logic [27:0] rdata_reg;
    logic [AW-1:0] clr_reg, clr_next;

    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    logic [27:0]   mem_wdata;

    logic [16:0] n_w;
    logic [27:0] n28, idx28;
    logic [3:0]  tb_bps;
    logic [2:0]  tb_spc;
    logic [4:0]  shift;
    logic [31:0] k_in;
    logic        cur_link, cur_ge_n, cur_eq_c, k_zero, wk_cont, wk_stop;

    function automatic logic is_link(input logic [27:0] v);
        is_link = (v >= cct_pkg::LINK_FIRST) && (v <= cct_pkg::LINK_LAST);
    endfunction

    assign n_w   = ({15'd0, te_reg} < 32'(TABLE_DEPTH)) ? te_reg : 17'(TABLE_DEPTH);
    assign n28   = {11'd0, n_w};
    assign idx28 = {11'd0, idx_reg};

    // only the highest set bit of each size counts
    always_comb
    begin
        tb_bps = 4'd0;
        tb_spc = 3'd0;
        for (int i = 0; i < 13; i++)
            if (bps_reg[i])
                tb_bps = 4'(i);
        for (int j = 0; j < 8; j++)
            if (spc_reg[j])
                tb_spc = 3'(j);
    end

    assign shift = {1'b0, tb_bps} + {2'b0, tb_spc};
    assign k_in  = ((item.command == cct_pkg::CMD_RESIZE) ? item.byte_count - 32'd1
                                                           : item.byte_count) >> shift;

    assign cur_link = is_link(cur_reg);
    assign cur_ge_n = cur_reg >= n28;
    assign cur_eq_c = cur_reg == c_reg;
    assign k_zero   = k_reg == 32'd0;

    always_comb
    begin
        case (cmd_reg)
            cct_pkg::CMD_FINDB:
                wk_cont = !k_zero && cur_link;
            cct_pkg::CMD_PREV, cct_pkg::CMD_DETACH:
                wk_cont = !cur_eq_c && cur_link;
            default:
                wk_cont = cur_link;
        endcase
    end

    assign wk_stop = cur_ge_n || (steps_reg >= n_w);

    assign sts.cmd        = cmd_reg;
    assign sts.c_ge_n     = c_reg >= n28;
    assign sts.c_bad      = !is_link(c_reg) || (c_reg >= n28);
    assign sts.c_zero     = c_reg == cct_pkg::LINK_FREE;
    assign sts.c_eq_oc    = c_reg == oc_reg;
    assign sts.nb_zero    = nb_reg == 32'd0;
    assign sts.idx_ge_n   = idx_reg >= n_w;
    assign sts.rd_zero    = rdata_reg == cct_pkg::LINK_FREE;
    assign sts.rd_link    = is_link(rdata_reg);
    assign sts.rd_ge_n    = rdata_reg >= n28;
    assign sts.i_eq_k     = {15'd0, steps_reg} == k_reg;
    assign sts.steps_ge_n = steps_reg >= n_w;
    assign sts.wk_go      = wk_cont && !wk_stop;
    assign sts.wk_err     = wk_cont && wk_stop;
    assign sts.clr_last   = clr_reg == AW'(TABLE_DEPTH - 1);

    assign result.result_cluster = res_reg;
    assign result.used_count     = cnt_reg;
    assign result.status         = st_reg;

    always_comb
    begin
        cmd_next   = cmd_reg;
        c_next     = c_reg;
        oc_next    = oc_reg;
        nb_next    = nb_reg;
        cur_next   = cur_reg;
        prev_next  = prev_reg;
        head_next  = head_reg;
        tgt_next   = tgt_reg;
        nx_next    = nx_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        steps_next = steps_reg;
        cnt_next   = cnt_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        clr_next   = clr_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = cur_reg[AW-1:0];
        mem_wdata  = cct_pkg::LINK_FREE;
        case (ctl.state)
            cct_pkg::S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + AW'(1);
            end
            cct_pkg::S_IDLE:
            begin
                if (ctl.accept)
                begin
                    cmd_next   = cct_pkg::cmd_t'(item.command);
                    c_next     = item.cluster;
                    oc_next    = item.other_cluster;
                    nb_next    = item.byte_count;
                    cur_next   = (item.command == cct_pkg::CMD_FINDB
                                  || item.command == cct_pkg::CMD_PREV
                                  || item.command == cct_pkg::CMD_DETACH)
                                 ? item.other_cluster : item.cluster;
                    prev_next  = cct_pkg::LINK_END;
                    head_next  = item.cluster;
                    tgt_next   = item.cluster;
                    k_next     = k_in;
                    idx_next   = 17'(cct_pkg::LINK_FIRST);
                    steps_next = 17'd0;
                    cnt_next   = 17'd0;
                    res_next   = (item.command == cct_pkg::CMD_DETACH)
                                 ? item.other_cluster : cct_pkg::LINK_FREE;
                    st_next    = cct_pkg::ST_OK;
                end
            end
            cct_pkg::S_DISP:
            begin
                case (cmd_reg)
                    cct_pkg::CMD_GET, cct_pkg::CMD_DETACH:
                    begin
                        if (sts.c_ge_n)
                            st_next = cct_pkg::ST_RANGE;
                        else
                        begin
                            mem_re   = 1'b1;
                            mem_addr = c_reg[AW-1:0];
                        end
                    end
                    cct_pkg::CMD_SET:
                    begin
                        if (sts.c_ge_n)
                            st_next = cct_pkg::ST_RANGE;
                        else
                        begin
                            mem_we    = 1'b1;
                            mem_addr  = c_reg[AW-1:0];
                            mem_wdata = oc_reg;
                        end
                    end
                    cct_pkg::CMD_RESIZE:
                    begin
                        if (!sts.nb_zero && !sts.c_zero && sts.c_bad)
                            st_next = cct_pkg::ST_RANGE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            cct_pkg::S_RW_EV:
                res_next = rdata_reg;
            cct_pkg::S_DT_EV:
            begin
                nx_next = rdata_reg;
                if (sts.c_eq_oc)
                begin
                    res_next = sts.rd_link ? rdata_reg : cct_pkg::LINK_FREE;
                    mem_we   = 1'b1;
                    mem_addr = c_reg[AW-1:0];
                end
            end
            cct_pkg::S_SC_CHK:
            begin
                if (sts.idx_ge_n)
                begin
                    if (cmd_reg != cct_pkg::CMD_COUNT)
                    begin
                        st_next  = cct_pkg::ST_RANGE;
                        res_next = (cmd_reg == cct_pkg::CMD_RESIZE && ctl.grow)
                                   ? head_reg : cct_pkg::LINK_END;
                    end
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_addr = idx28[AW-1:0];
                end
            end
            cct_pkg::S_SC_EV:
            begin
                if (cmd_reg == cct_pkg::CMD_COUNT)
                begin
                    cnt_next = cnt_reg + {16'd0, !sts.rd_zero};
                    idx_next = idx_reg + 17'd1;
                end
                else if (sts.rd_zero)
                begin
                    // claim the entry and mark it end of chain
                    mem_we    = 1'b1;
                    mem_addr  = idx28[AW-1:0];
                    mem_wdata = cct_pkg::LINK_END;
                    if (cmd_reg == cct_pkg::CMD_ALLOC)
                        res_next = idx28;
                    else if (!ctl.grow)
                    begin
                        head_next = idx28;
                        tgt_next  = idx28;
                    end
                end
                else
                    idx_next = idx_reg + 17'd1;
            end
            cct_pkg::S_GR_CHK:
            begin
                if (!sts.i_eq_k && sts.steps_ge_n)
                begin
                    st_next  = cct_pkg::ST_LIMIT;
                    res_next = head_reg;
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_addr = tgt_reg[AW-1:0];
                end
            end
            cct_pkg::S_GR_EV:
            begin
                if (!sts.rd_link)
                    idx_next = 17'(cct_pkg::LINK_FIRST);
                else if (sts.rd_ge_n)
                begin
                    st_next  = cct_pkg::ST_RANGE;
                    res_next = head_reg;
                end
                else
                begin
                    tgt_next   = rdata_reg;
                    steps_next = steps_reg + 17'd1;
                end
            end
            cct_pkg::S_GR_LINK:
            begin
                mem_we     = 1'b1;
                mem_addr   = tgt_reg[AW-1:0];
                mem_wdata  = idx28;
                tgt_next   = idx28;
                steps_next = steps_reg + 17'd1;
            end
            cct_pkg::S_TL_EV:
            begin
                if (sts.rd_link)
                begin
                    cur_next   = rdata_reg;
                    steps_next = 17'd0;
                end
                else
                    res_next = head_reg;
            end
            cct_pkg::S_WK_CHK:
            begin
                if (sts.wk_go)
                    mem_re = 1'b1;
                else if (sts.wk_err)
                begin
                    st_next = cur_ge_n ? cct_pkg::ST_RANGE : cct_pkg::ST_LIMIT;
                    case (cmd_reg)
                        cct_pkg::CMD_LAST:  res_next = prev_reg;
                        cct_pkg::CMD_FINDB: res_next = cur_reg;
                        cct_pkg::CMD_PREV:  res_next = cct_pkg::LINK_FREE;
                        default:            res_next = res_reg;
                    endcase
                end
                else
                begin
                    case (cmd_reg)
                        cct_pkg::CMD_LAST:  res_next = prev_reg;
                        cct_pkg::CMD_FINDB: res_next = cur_reg;
                        cct_pkg::CMD_PREV:
                            res_next = cur_eq_c ? prev_reg : cct_pkg::LINK_FREE;
                        cct_pkg::CMD_DETACH:
                        begin
                            // bridge the predecessor over the detached cluster
                            if (cur_eq_c)
                            begin
                                mem_we    = 1'b1;
                                mem_addr  = prev_reg[AW-1:0];
                                mem_wdata = nx_reg;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            cct_pkg::S_WK_EV:
            begin
                steps_next = steps_reg + 17'd1;
                cur_next   = rdata_reg;
                case (cmd_reg)
                    cct_pkg::CMD_FREE, cct_pkg::CMD_RESIZE:
                        mem_we = 1'b1;
                    cct_pkg::CMD_FINDB:
                        k_next = k_reg - 32'd1;
                    default:
                        prev_next = cur_reg;
                endcase
            end
            cct_pkg::S_DT_FREE:
            begin
                mem_we   = 1'b1;
                mem_addr = c_reg[AW-1:0];
            end
            cct_pkg::S_TL_END:
            begin
                mem_we    = 1'b1;
                mem_addr  = tgt_reg[AW-1:0];
                mem_wdata = cct_pkg::LINK_END;
                res_next  = head_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bps_reg <= 13'd512;
            spc_reg <= 8'd8;
            te_reg  <= 17'd65536;
            clr_reg <= '0;
        end
        else
        begin
            clr_reg <= clr_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    cct_pkg::CFG_BPS: bps_reg <= cfg_data[12:0];
                    cct_pkg::CFG_SPC: spc_reg <= cfg_data[7:0];
                    cct_pkg::CFG_TE:  te_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        c_reg     <= c_next;
        oc_reg    <= oc_next;
        nb_reg    <= nb_next;
        cur_reg   <= cur_next;
        prev_reg  <= prev_next;
        head_reg  <= head_next;
        tgt_reg   <= tgt_next;
        nx_reg    <= nx_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        steps_reg <= steps_next;
        cnt_reg   <= cnt_next;
        res_reg   <= res_next;
        st_reg    <= st_next;
    end

endmodule

### hw/rtl/cluster_chain_table_engine.sv
`timescale 1ns / 1ps
// Cluster chain table engine: a FAT32-style table of 28-bit next-cluster links held in one
// single-port memory of TABLE_DEPTH entries. After reset the block sweeps the memory to
// zero, one entry a cycle, and keeps busy high until the sweep ends. A command is taken
// when start is high and busy is low; its one result appears for a single cycle with done
// high and must be captured then, as the receiver cannot stall it. Each state makes at most
// one memory access: get reads then returns the entry, set writes it, count and allocate read
// and test each scanned entry, walks follow each link, resize scans per appended cluster.
// Configuration registers may be written whenever no command is in flight.
module cluster_chain_table_engine #(
    parameter int TABLE_DEPTH = cct_pkg::TABLE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cct_pkg::item_t   item,
    output logic             done,
    output cct_pkg::result_t result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_data
);

    cct_pkg::ctl_t ctl;
    cct_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    cct_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    cct_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .item      (item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .result    (result),
        .sts       (sts)
    );

endmodule

### hw/rtl/cct_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cct_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input logic             done,
    input cct_pkg::result_t result
);

    `CHK_ASSERT(a_done_busy, done |-> busy, "result shown while not busy")
    `CHK_ASSERT(a_take_busy, (start && !busy) |=> busy, "item taken but busy stays low")
    `CHK_ASSERT(a_done_once, done |=> !done, "result strobe held past one cycle")
    `CHK_NEVER(a_status_code, done && result.status > cct_pkg::ST_LIMIT, "undefined status code")
    `CHK_ASSERT(a_count_only, (done && result.used_count != 17'd0) |-> (result.result_cluster == cct_pkg::LINK_FREE && result.status == cct_pkg::ST_OK), "count mixed with other data")

endmodule

bind cluster_chain_table_engine cct_checker u_cct_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
